### src/rmth_pkg.sv
// ----------------------------------------------------------------------------
// rmth_pkg: shared types and constants for the running median block
// Heap geometry, sum constants, heap and sequencer states and the heap engine command and status structs.
// ----------------------------------------------------------------------------
package rmth_pkg;

  localparam int HeapDepth = 4096;
  localparam int AddrW     = $clog2(HeapDepth);
  localparam int CntW      = $clog2(HeapDepth + 1);
  localparam int SumW      = 15;
  localparam int SumMod    = 10000;

  // reciprocal of SumMod scaled by 2^SumShift, rounded up; the quotient it
  // gives is exact for every 32-bit magnitude
  localparam logic [31:0] SumRecip = 32'hD1B7_1759;
  localparam int          SumShift = 45;
  localparam int          QuoW     = 64 - SumShift;

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_POP
  } heap_op_e;

  typedef struct packed {
    logic              start;
    heap_op_e          op;
    logic              is_max;
    logic signed [31:0] value;
  } heap_cmd_t;

  typedef struct packed {
    logic              done;
    logic signed [31:0] top;
    logic [CntW-1:0]    count;
  } heap_sts_t;

  typedef enum logic [3:0] {
    H_IDLE,
    H_PUSH_WR,
    H_UP_RD,
    H_UP_CMP,
    H_POP_RD_LAST,
    H_POP_WR_ROOT,
    H_DN_RD_L,
    H_DN_RD_R,
    H_DN_CMP,
    H_DONE
  } heap_state_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_REBAL_POP,
    S_REBAL_PUSH,
    S_SUM,
    S_MUL,
    S_REM,
    S_OUT
  } seq_state_e;

endpackage

### src/rmth_heap.sv
// ----------------------------------------------------------------------------
// rmth_heap: one binary heap in a single-port memory
// Push sifts up and pop sifts down, one memory access per cycle through a
// common compare function. The root is mirrored in a register for fast peeking.
// ----------------------------------------------------------------------------
module rmth_heap
  import rmth_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  heap_cmd_t cmd_i,
  output heap_sts_t sts_o
);

  logic signed [31:0] mem [HeapDepth];

  heap_state_e        state_q, state_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [AddrW-1:0]   idx_q, idx_d, oth_q, oth_d, best_q, best_d;
  logic signed [31:0] cur_q, cur_d, cand_q, cand_d, top_q, top_d;
  logic               max_q, max_d;
  logic [CntW-1:0]    n_q, n_d;

  logic               we;
  logic [AddrW-1:0]   waddr, raddr;
  logic signed [31:0] wdata, rdata_q;
  logic               re;

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  // shared compare: does a belong above b
  function automatic logic above(logic signed [31:0] a, logic signed [31:0] b, logic mx);
    return mx ? (a > b) : (a < b);
  endfunction

  logic [CntW:0]      lchild, rchild;
  logic [AddrW-1:0]   parent;
  logic               r_win, dn_swap;
  logic [AddrW-1:0]   win_idx;
  logic signed [31:0] win_val;

  assign lchild  = {1'b0, idx_q, 1'b1};
  assign rchild  = lchild + (CntW+1)'(1);
  assign parent  = (idx_q - AddrW'(1)) >> 1;
  // right child wins only if it exists and beats the best so far
  assign r_win   = (rchild < {1'b0, n_q}) && above(rdata_q, cand_q, max_q);
  assign dn_swap = r_win || (best_q != idx_q);
  assign win_idx = r_win ? rchild[AddrW-1:0] : best_q;
  assign win_val = r_win ? rdata_q : cand_q;

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; idx_d = idx_q; oth_d = oth_q; best_d = best_q;
    cur_d = cur_q; cand_d = cand_q; top_d = top_q; max_d = max_q; n_d = n_q;
    case (state_q)
      H_IDLE, H_DONE: begin
        state_d = H_IDLE;
        if (cmd_i.start) begin
          max_d = cmd_i.is_max;
          if (cmd_i.op == OP_PUSH) begin
            cur_d = cmd_i.value;
            idx_d = cnt_q[AddrW-1:0];
            cnt_d = cnt_q + CntW'(1);
            state_d = H_PUSH_WR;
          end else begin
            n_d = cnt_q - CntW'(1);
            cnt_d = cnt_q - CntW'(1);
            idx_d = '0;
            state_d = H_POP_RD_LAST;
          end
        end
      end
      H_PUSH_WR: begin
        if (idx_q == '0) begin
          top_d = cur_q;
          state_d = H_DONE;
        end else begin
          oth_d = parent;
          state_d = H_UP_RD;
        end
      end
      H_UP_RD: state_d = H_UP_CMP;
      H_UP_CMP: begin
        if (above(cur_q, rdata_q, max_q)) begin
          idx_d = oth_q;
          state_d = H_PUSH_WR;
        end else begin
          state_d = H_DONE;
        end
      end
      H_POP_RD_LAST: state_d = H_POP_WR_ROOT;
      H_POP_WR_ROOT: begin
        cur_d = rdata_q;
        top_d = rdata_q;
        state_d = H_DN_RD_L;
      end
      H_DN_RD_L: begin
        if (lchild >= {1'b0, n_q}) begin
          state_d = H_DONE;
        end else begin
          state_d = H_DN_RD_R;
        end
      end
      H_DN_RD_R: begin
        cand_d = cur_q;
        best_d = idx_q;
        if (above(rdata_q, cur_q, max_q)) begin
          cand_d = rdata_q;
          best_d = lchild[AddrW-1:0];
        end
        state_d = H_DN_CMP;
      end
      H_DN_CMP: begin
        state_d = H_DONE;
        if (dn_swap) begin
          idx_d = win_idx;
          state_d = H_DN_RD_L;
          if (idx_q == '0) begin
            top_d = win_val;
          end
        end
      end
      default: state_d = H_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    we = 1'b0; waddr = idx_q; wdata = cur_q; re = 1'b0; raddr = idx_q;
    case (state_q)
      H_PUSH_WR: begin
        we = 1'b1;
      end
      H_UP_RD: begin
        re = 1'b1; raddr = oth_q;
      end
      H_UP_CMP: begin
        // swap: parent value moves down into the current slot
        if (above(cur_q, rdata_q, max_q)) begin
          we = 1'b1; wdata = rdata_q;
        end
      end
      H_POP_RD_LAST: begin
        re = 1'b1; raddr = n_q[AddrW-1:0];
      end
      H_POP_WR_ROOT: begin
        we = 1'b1; waddr = '0; wdata = rdata_q;
      end
      H_DN_RD_L: begin
        re = 1'b1; raddr = lchild[AddrW-1:0];
      end
      H_DN_RD_R: begin
        re = 1'b1; raddr = rchild[AddrW-1:0];
      end
      H_DN_CMP: begin
        // swap: winner child moves up into the current slot
        if (dn_swap) begin
          we = 1'b1;
          wdata = win_val;
        end
      end
      H_DONE: begin
        // park the moving value in its final slot
        we = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; oth_q <= oth_d; best_q <= best_d; cur_q <= cur_d;
    cand_q <= cand_d; top_q <= top_d; max_q <= max_d; n_q <= n_d;
  end

  assign sts_o.done  = (state_q == H_DONE);
  assign sts_o.top   = top_q;
  assign sts_o.count = cnt_q;

endmodule

### src/running_median_two_heaps_top.sv
// ----------------------------------------------------------------------------
// running_median_two_heaps_top: streaming median over two heaps
// Keeps a max-heap of the lower half and a min-heap of the upper half.
// ----------------------------------------------------------------------------
// An insert pushes into one heap and sifts up; a rebalance then pops the larger
// heap's top, sifts down and pushes the moved value into the other heap with a
// second sift-up. A dropped request answers in the cycle after acceptance. One
// request in flight; input is ready again the cycle after the result is taken.
// Reset clears counts, sum and control; heap memories are not cleared.
module running_median_two_heaps_top
  import rmth_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               sample_valid_i,
  output logic               sample_ready_o,
  input  logic signed [31:0] sample_i,
  output logic               result_valid_o,
  input  logic               result_ready_i,
  output logic signed [31:0] median_o,
  output logic signed [14:0] median_sum_o,
  output logic               overflow_o
);

  seq_state_e         state_q, state_d;
  heap_cmd_t          lo_cmd, up_cmd;
  heap_sts_t          lo_sts, up_sts;
  logic               to_up;
  logic               drop_q, drop_d;
  logic               from_up_q, from_up_d;
  logic signed [31:0] mv_q, mv_d;
  logic signed [SumW-1:0] acc_q, acc_d;
  logic signed [31:0] med;
  logic signed [32:0] tsum, tneg;
  logic [31:0]        mag_q, mag_d;
  logic               neg_q, neg_d;
  logic [63:0]        prod;
  logic [QuoW-1:0]    quo_q, quo_d;
  logic [32:0]        quo_mul, rem_full;
  logic [SumW-1:0]    rem;

  rmth_heap u_lo (.clk_i, .rst_ni, .cmd_i(lo_cmd), .sts_o(lo_sts));
  rmth_heap u_up (.clk_i, .rst_ni, .cmd_i(up_cmd), .sts_o(up_sts));

  assign med = (up_sts.count > lo_sts.count) ? up_sts.top :
               (lo_sts.count != '0) ? lo_sts.top : 32'sd0;

  // Equal to the upper minimum still goes low
  assign to_up = (up_sts.count != '0) && (sample_i > up_sts.top);

  // Truncating remainder over three steps: take the magnitude of the new sum,
  // divide it by reciprocal multiplication, then subtract the quotient times
  // the modulus and restore the sign of the sum.
  assign tsum     = 33'(acc_q) + 33'(med);
  assign tneg     = -tsum;
  assign prod     = {32'd0, mag_q} * {32'd0, SumRecip};
  assign quo_mul  = 33'(quo_q) * 33'(SumMod);
  assign rem_full = {1'b0, mag_q} - quo_mul;
  assign rem      = {1'b0, rem_full[SumW-2:0]};

  always_comb begin
    state_d = state_q;
    drop_d = drop_q; from_up_d = from_up_q;
    mv_d = mv_q; acc_d = acc_q;
    mag_d = mag_q; neg_d = neg_q; quo_d = quo_q;
    lo_cmd = '0; up_cmd = '0;
    lo_cmd.is_max = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (sample_valid_i) begin
          drop_d = to_up ? (up_sts.count >= CntW'(HeapDepth))
                         : (lo_sts.count >= CntW'(HeapDepth));
          if (drop_d) begin
            state_d = S_OUT;
          end else begin
            state_d = S_INSERT;
            up_cmd.start = to_up; up_cmd.op = OP_PUSH; up_cmd.value = sample_i;
            lo_cmd.start = !to_up; lo_cmd.op = OP_PUSH; lo_cmd.value = sample_i;
          end
        end
      end
      S_INSERT: begin
        if (lo_sts.done || up_sts.done) begin
          if (up_sts.count > lo_sts.count + CntW'(1)) begin
            from_up_d = 1'b1; up_cmd.start = 1'b1; up_cmd.op = OP_POP;
            mv_d = up_sts.top; state_d = S_REBAL_POP;
          end else if (lo_sts.count > up_sts.count + CntW'(1)) begin
            from_up_d = 1'b0; lo_cmd.start = 1'b1; lo_cmd.op = OP_POP;
            mv_d = lo_sts.top; state_d = S_REBAL_POP;
          end else begin
            state_d = S_SUM;
          end
        end
      end
      S_REBAL_POP: begin
        if (lo_sts.done || up_sts.done) begin
          lo_cmd.start = from_up_q; lo_cmd.op = OP_PUSH; lo_cmd.value = mv_q;
          up_cmd.start = !from_up_q; up_cmd.op = OP_PUSH; up_cmd.value = mv_q;
          state_d = S_REBAL_PUSH;
        end
      end
      S_REBAL_PUSH: begin
        if (lo_sts.done || up_sts.done) state_d = S_SUM;
      end
      S_SUM: begin
        mag_d = tsum[32] ? tneg[31:0] : tsum[31:0];
        neg_d = tsum[32];
        state_d = S_MUL;
      end
      S_MUL: begin
        quo_d = prod[63:SumShift];
        state_d = S_REM;
      end
      S_REM: begin
        acc_d = neg_q ? $signed(-rem) : $signed(rem);
        state_d = S_OUT;
      end
      S_OUT: begin
        if (result_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      acc_q   <= '0;
    end else begin
      state_q <= state_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    drop_q <= drop_d; from_up_q <= from_up_d;
    mv_q <= mv_d;
    mag_q <= mag_d; neg_q <= neg_d; quo_q <= quo_d;
  end

  assign sample_ready_o = (state_q == S_IDLE);
  assign result_valid_o = (state_q == S_OUT);
  assign median_o       = med;
  assign median_sum_o   = acc_q;
  assign overflow_o     = drop_q;

endmodule
